// File: src/odo_pkg.sv
package odo_pkg;

  // Register indexes on the configuration port.
  localparam logic RegDistPerCount = 1'b0;
  localparam logic RegTrackWidth   = 1'b1;

  // Operation codes of an input request.
  localparam logic OpSample = 1'b0;
  localparam logic OpLoad   = 1'b1;

  // Register reset values.
  localparam logic [27:0] DpcReset = 28'd29033979;
  localparam logic [19:0] TwReset  = 20'd26411;

  // Angles in Q4.28 radians, held at 33 bits so that sums do not overflow.
  localparam logic signed [32:0] PiQ     = 33'sd843314857;
  localparam logic signed [32:0] HalfPiQ = 33'sd421657428;
  localparam logic signed [32:0] TwoPiQ  = 33'sd1686629714;

  // CORDIC start value: gain 1/K preloaded, Q2.30.
  localparam logic signed [32:0] KQ30 = 33'sd652032874;

  // Number of CORDIC rotations, capped by the size of the arctangent table.
  localparam int CordicSteps = 24;
  localparam int CordicIters = (CordicSteps < 30) ? CordicSteps : 30;
  localparam int CordicCntW  = $clog2(CordicIters);

  // Count value of the last rotation.
  localparam logic [CordicCntW-1:0] CordicLast = CordicCntW'(CordicIters - 1);

  // Arctangent of 2^-i in Q4.28.
  function automatic logic signed [31:0] atan_lut(input logic [4:0] idx);
    logic signed [31:0] v;
    unique case (idx)
      5'd0:    v = 32'sd210828714;
      5'd1:    v = 32'sd124459457;
      5'd2:    v = 32'sd65760959;
      5'd3:    v = 32'sd33381290;
      5'd4:    v = 32'sd16755422;
      5'd5:    v = 32'sd8385879;
      5'd6:    v = 32'sd4193963;
      5'd7:    v = 32'sd2097109;
      5'd8:    v = 32'sd1048571;
      5'd9:    v = 32'sd524287;
      5'd10:   v = 32'sd262144;
      5'd11:   v = 32'sd131072;
      5'd12:   v = 32'sd65536;
      5'd13:   v = 32'sd32768;
      5'd14:   v = 32'sd16384;
      5'd15:   v = 32'sd8192;
      5'd16:   v = 32'sd4096;
      5'd17:   v = 32'sd2048;
      5'd18:   v = 32'sd1024;
      5'd19:   v = 32'sd512;
      5'd20:   v = 32'sd256;
      5'd21:   v = 32'sd128;
      5'd22:   v = 32'sd64;
      5'd23:   v = 32'sd32;
      5'd24:   v = 32'sd16;
      5'd25:   v = 32'sd8;
      5'd26:   v = 32'sd4;
      5'd27:   v = 32'sd2;
      5'd28:   v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/odo_cordic.sv
module odo_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [30:0] angle_i,
  output logic               busy_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic signed [32:0] x_q, y_q;
  logic signed [31:0] z_q;
  logic               neg_q;
  logic               busy_q;
  logic [odo_pkg::CordicCntW-1:0] cnt_q;

  logic signed [32:0] ang_ext, ang_fold;
  logic               fold;
  logic signed [32:0] xs, ys, x_n, y_n;
  logic signed [31:0] z_n, at;

  // Fold the angle into [-pi/2, pi/2]; a folded angle's results are negated afterwards.
  always_comb begin
    ang_ext = 33'(angle_i);
    fold    = 1'b0;
    ang_fold = ang_ext;
    if (ang_ext > odo_pkg::HalfPiQ) begin
      ang_fold = ang_ext - odo_pkg::PiQ;
      fold     = 1'b1;
    end else if (ang_ext < -odo_pkg::HalfPiQ) begin
      ang_fold = ang_ext + odo_pkg::PiQ;
      fold     = 1'b1;
    end
  end

  // One rotation per cycle, steered by the sign of the residual angle.
  always_comb begin
    xs = x_q >>> cnt_q;
    ys = y_q >>> cnt_q;
    at = odo_pkg::atan_lut(5'(cnt_q));
    if (z_q >= 0) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - at;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
      neg_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      x_q    <= odo_pkg::KQ30;
      y_q    <= '0;
      z_q    <= ang_fold[31:0];
      neg_q  <= fold;
    end else if (busy_q) begin
      x_q   <= x_n;
      y_q   <= y_n;
      z_q   <= z_n;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == odo_pkg::CordicLast) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign cos_o  = neg_q ? -x_q[31:0] : x_q[31:0];
  assign sin_o  = neg_q ? -y_q[31:0] : y_q[31:0];

endmodule

// File: src/odo_div.sv
module odo_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [71:0] dividend_i,
  input  logic [19:0] divisor_i,
  output logic        done_o,
  output logic        ovf_o,
  output logic [31:0] quot_o
);

  logic [19:0] rem_q;
  logic [31:0] low_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q, ovf_q;

  logic [20:0] trial, diff;
  logic        ge;

  // Restoring step: shift in one dividend bit, subtract the divisor if it fits.
  always_comb begin
    trial = {rem_q, low_q[31]};
    ge    = trial >= {1'b0, divisor_i};
    diff  = trial - {1'b0, divisor_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      low_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // A quotient of 2^32 or more shows already in the upper dividend bits.
        busy_q <= 1'b1;
        cnt_q  <= '0;
        ovf_q  <= dividend_i[71:32] >= {20'd0, divisor_i};
        rem_q  <= dividend_i[51:32];
        low_q  <= dividend_i[31:0];
      end else if (busy_q) begin
        rem_q <= ge ? diff[19:0] : trial[19:0];
        low_q <= {low_q[30:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quot_o = low_q;

endmodule

// File: src/differential_drive_odometry_top.sv
// Wheel odometry for a two-wheel robot.
// Input channel (in_valid_i/in_ready_o): one request per encoder sample
// (op_i = sample) or per pose load (op_i = load). Output channel
// (out_valid_o/out_ready_i): one result per request, the pose after it
// plus linear and angular velocity.
// A pose load goes straight to the output register. For a sample, the
// mean travel and heading change go through one
// shared 33x31 multiplier, two 32-step passes of the bit-serial divider
// (heading change, angular velocity) and then four multiplier passes for
// the x and y steps; the CORDIC runs its rotations alongside the divider.
// One request is in work at a time: in_ready_o is high only while idle,
// so a new request is taken only once the last result is in the output register.
// A finished result sits in the output register; if the receiver stalls,
// the next request can still be taken and worked, and its result waits
// until the register is free.
// Reset clears the pose, the stored encoder counts and the output valid,
// and loads the default distance per count and track width.
// Configuration writes go through cfg_we_i/cfg_addr_i/cfg_wdata_i and
// take effect at once; the user makes them only while idle (not enforced).
module differential_drive_odometry_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_addr_i,
  input  logic [27:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic signed [31:0] left_count_i,
  input  logic signed [31:0] right_count_i,
  input  logic signed [15:0] left_rate_i,
  input  logic signed [15:0] right_rate_i,
  input  logic signed [31:0] new_x_i,
  input  logic signed [31:0] new_y_i,
  input  logic signed [30:0] new_heading_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [30:0] pos_heading_o,
  output logic signed [31:0] lin_velocity_o,
  output logic signed [31:0] ang_velocity_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_S, S_MUL_DIFF, S_MUL_SD, S_MUL_LIN, S_LIN, S_DIV_H, S_HEAD,
    S_DIV_A, S_CORDIC, S_M_LO, S_M_HI, S_M_SUM, S_ACC, S_DONE
  } state_e;

  state_e state_q;

  logic [27:0] dpc_q;
  logic [19:0] tw_q;
  logic [19:0] tw_eff;

  logic [31:0] last_l_q, last_r_q;
  logic signed [31:0] x_q, y_q;
  logic signed [30:0] heading_q;

  logic signed [32:0] s_q, diff_q;
  logic signed [16:0] sdp_q, sdm_q;
  logic [59:0] dist_q;
  logic [44:0] num_ang_q;
  logic [62:0] plo_q;
  logic [31:0] mag_q;
  logic signed [32:0] dh_q;
  logic signed [31:0] lin_q, ang_q;
  logic sel_y_q;

  logic out_valid_q;
  logic signed [31:0] out_x_q, out_y_q, out_lin_q, out_ang_q;
  logic signed [30:0] out_h_q;

  logic [32:0] mul_a;
  logic [30:0] mul_b;
  logic [63:0] prod_q;

  logic        in_acc;
  logic [31:0] dl, dr;
  logic        cordic_start, cordic_busy;
  logic signed [31:0] cos_v, sin_v, trig;
  logic [30:0] trig_abs;
  logic        div_start, div_done, div_ovf;
  logic [71:0] div_dividend;
  logic [31:0] div_quot;
  logic [30:0] q_sat;
  logic [91:0] prod_sum;

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // Wrap once into (-pi, pi].
  function automatic logic signed [30:0] wrap_h(input logic signed [32:0] h);
    logic signed [32:0] r;
    r = h;
    if (h > odo_pkg::PiQ) begin
      r = h - odo_pkg::TwoPiQ;
    end else if (h <= -odo_pkg::PiQ) begin
      r = h + odo_pkg::TwoPiQ;
    end
    return r[30:0];
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign tw_eff     = (tw_q == '0) ? 20'd1 : tw_q;

  assign dl = left_count_i - last_l_q;
  assign dr = right_count_i - last_r_q;

  // CORDIC on the old heading starts with the sample.
  assign cordic_start = in_acc && (op_i == odo_pkg::OpSample);

  odo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (heading_q),
    .busy_o  (cordic_busy),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // The divider first yields the heading change, then the angular velocity.
  assign div_start    = (state_q == S_MUL_SD) || (state_q == S_HEAD);
  assign div_dividend = (state_q == S_MUL_SD) ? {prod_q[59:0], 12'd0}
                                              : {27'd0, num_ang_q};

  odo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (tw_eff),
    .done_o     (div_done),
    .ovf_o      (div_ovf),
    .quot_o     (div_quot)
  );

  assign q_sat = (div_ovf || (div_quot > 32'(odo_pkg::TwoPiQ))) ?
                 31'(odo_pkg::TwoPiQ) : div_quot[30:0];

  assign trig     = sel_y_q ? sin_v : cos_v;
  assign trig_abs = trig[31] ? 31'(-trig) : trig[30:0];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = {3'd0, dpc_q};
    unique case (state_q)
      S_MUL_S:    mul_a = abs33(s_q);
      S_MUL_DIFF: mul_a = abs33(diff_q);
      S_MUL_SD:   mul_a = abs33(33'(sdm_q));
      S_MUL_LIN:  mul_a = abs33(33'(sdp_q));
      S_M_LO: begin
        mul_a = {1'b0, dist_q[31:0]};
        mul_b = trig_abs;
      end
      S_M_HI: begin
        mul_a = {5'd0, dist_q[59:32]};
        mul_b = trig_abs;
      end
      default: mul_a = '0;
    endcase
  end

  // Upper partial product shifted up by 32, plus the lower one.
  assign prod_sum = {prod_q[59:0], 32'd0} + {29'd0, plo_q};

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dpc_q       <= odo_pkg::DpcReset;
      tw_q        <= odo_pkg::TwReset;
      last_l_q    <= '0;
      last_r_q    <= '0;
      x_q         <= '0;
      y_q         <= '0;
      heading_q   <= '0;
      s_q         <= '0;
      diff_q      <= '0;
      sdp_q       <= '0;
      sdm_q       <= '0;
      dist_q      <= '0;
      num_ang_q   <= '0;
      plo_q       <= '0;
      mag_q       <= '0;
      dh_q        <= '0;
      lin_q       <= '0;
      ang_q       <= '0;
      sel_y_q     <= 1'b0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_h_q     <= '0;
      out_lin_q   <= '0;
      out_ang_q   <= '0;
    end else begin
      prod_q <= mul_a * mul_b;

      if (cfg_we_i) begin
        if (cfg_addr_i == odo_pkg::RegDistPerCount) begin
          dpc_q <= cfg_wdata_i;
        end else begin
          tw_q <= cfg_wdata_i[19:0];
        end
      end

      // A taken result frees the register unless the next one moves in now.
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (op_i == odo_pkg::OpLoad) begin
              x_q       <= new_x_i;
              y_q       <= new_y_i;
              heading_q <= wrap_h(33'(new_heading_i));
              lin_q     <= '0;
              ang_q     <= '0;
              state_q   <= S_DONE;
            end else begin
              last_l_q <= left_count_i;
              last_r_q <= right_count_i;
              s_q      <= 33'(signed'(dl)) + 33'(signed'(dr));
              diff_q   <= 33'(signed'(dr)) - 33'(signed'(dl));
              sdp_q    <= 17'(right_rate_i) + 17'(left_rate_i);
              sdm_q    <= 17'(right_rate_i) - 17'(left_rate_i);
              sel_y_q  <= 1'b0;
              state_q  <= S_MUL_S;
            end
          end
        end
        S_MUL_S:    state_q <= S_MUL_DIFF;
        S_MUL_DIFF: begin
          dist_q  <= prod_q[59:0];
          state_q <= S_MUL_SD;
        end
        S_MUL_SD:   state_q <= S_MUL_LIN;
        S_MUL_LIN: begin
          num_ang_q <= prod_q[44:0];
          state_q   <= S_LIN;
        end
        S_LIN: begin
          lin_q   <= sdp_q[16] ? -{5'd0, prod_q[43:17]} : {5'd0, prod_q[43:17]};
          state_q <= S_DIV_H;
        end
        S_DIV_H: begin
          if (div_done) begin
            dh_q    <= diff_q[32] ? -33'(q_sat) : 33'(q_sat);
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          heading_q <= wrap_h(33'(heading_q) + dh_q);
          state_q   <= S_DIV_A;
        end
        S_DIV_A: begin
          if (div_done) begin
            if (sdm_q[16]) begin
              ang_q <= (div_ovf || (div_quot > 32'h8000_0000)) ? 32'sh8000_0000
                                                               : -div_quot;
            end else begin
              ang_q <= (div_ovf || div_quot[31]) ? 32'sh7FFF_FFFF : div_quot;
            end
            state_q <= S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (!cordic_busy) begin
            state_q <= S_M_LO;
          end
        end
        S_M_LO:  state_q <= S_M_HI;
        S_M_HI: begin
          plo_q   <= prod_q[62:0];
          state_q <= S_M_SUM;
        end
        S_M_SUM: begin
          mag_q   <= prod_sum[78:47];
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (sel_y_q) begin
            y_q     <= (s_q[32] ^ trig[31]) ? y_q - mag_q : y_q + mag_q;
            state_q <= S_DONE;
          end else begin
            x_q     <= (s_q[32] ^ trig[31]) ? x_q - mag_q : x_q + mag_q;
            sel_y_q <= 1'b1;
            state_q <= S_M_LO;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_x_q     <= x_q;
            out_y_q     <= y_q;
            out_h_q     <= heading_q;
            out_lin_q   <= lin_q;
            out_ang_q   <= ang_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = out_x_q;
  assign pos_y_o        = out_y_q;
  assign pos_heading_o  = out_h_q;
  assign lin_velocity_o = out_lin_q;
  assign ang_velocity_o = out_ang_q;

endmodule

// File: src/odo_checker.sv
module odo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               op_i,
  input logic signed [31:0] new_x_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] pos_x_o,
  input logic signed [31:0] ang_velocity_o
);

  // A taken request keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a request");

  // A pose load into a free output shows the new x and zero angular velocity after S_DONE writes the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i == odo_pkg::OpLoad) && !out_valid_o) |=> ##1
    (out_valid_o && (pos_x_o == $past(new_x_i, 2)) && (ang_velocity_o == '0)))
    else $error("pose load result wrong");

  // A stalled result stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped under stall");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(pos_x_o))
    else $error("result changed under stall");

endmodule

bind differential_drive_odometry_top odo_checker u_odo_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .op_i           (op_i),
  .new_x_i        (new_x_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .pos_x_o        (pos_x_o),
  .ang_velocity_o (ang_velocity_o)
);

// File: test/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemCount = 1350;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic               op;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] left_rate;
    logic signed [15:0] right_rate;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [30:0] new_heading;
  } odo_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [30:0] pos_heading;
    logic signed [31:0] lin_velocity;
    logic signed [31:0] ang_velocity;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_addr_i;
  logic [27:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic op_i;
  logic signed [31:0] left_count_i, right_count_i, new_x_i, new_y_i;
  logic signed [15:0] left_rate_i, right_rate_i;
  logic signed [30:0] new_heading_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [31:0] pos_x_o, pos_y_o, lin_velocity_o, ang_velocity_o;
  logic signed [30:0] pos_heading_o;

  differential_drive_odometry_top u_dut (.*);

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and configuration.
  logic [27:0] dpc;
  logic [19:0] track;
  logic [31:0] prev_left, prev_right, px, py, phead;
  logic signed [31:0] cur_left, cur_right;

  odo_req_t pending_reqs[$];
  pose_t    expected_poses[$];
  int       errors;
  int       idle_cycles;
  bit       hold_off;
  bit       stim_done;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_table(int i);
    return longint'(odo_pkg::atan_lut(5'(i)));
  endfunction

  function automatic longint fold_heading(longint h);
    if (h > longint'(odo_pkg::PiQ)) return h - longint'(odo_pkg::TwoPiQ);
    if (h <= -longint'(odo_pkg::PiQ)) return h + longint'(odo_pkg::TwoPiQ);
    return h;
  endfunction

  // Truncating (a * c) / 2^47 with a 128-bit product.
  function automatic longint scale47(longint a, longint c);
    logic signed [127:0] p;
    logic [127:0] m;
    longint r;
    p = 128'(signed'(a)) * 128'(signed'(c));
    m = p < 0 ? -p : p;
    r = longint'(m >> 47);
    return p < 0 ? -r : r;
  endfunction

  // Apply one request to the predicted pose and return the expected result.
  function automatic pose_t odo_predict(odo_req_t rq);
    pose_t res;
    longint dl, dr, h, cx, cy, cz, t, travel, diff, dh, sd, lin, ang;
    longint unsigned num, qh, q, mag, tw;
    bit neg;
    tw = (track == 0) ? 1 : track;
    lin = 0;
    ang = 0;
    if (rq.op == odo_pkg::OpLoad) begin
      px = rq.new_x;
      py = rq.new_y;
      phead = 32'(fold_heading(longint'(rq.new_heading)));
    end else begin
      dl = longint'($signed(32'(rq.left_count - prev_left)));
      dr = longint'($signed(32'(rq.right_count - prev_right)));
      prev_left = rq.left_count;
      prev_right = rq.right_count;
      h = longint'($signed(phead));
      // Rotation-mode CORDIC with fold by pi for angles beyond +-pi/2.
      cx = odo_pkg::KQ30;
      cy = 0;
      cz = h;
      neg = 0;
      if (cz > longint'(odo_pkg::HalfPiQ)) begin
        cz -= odo_pkg::PiQ;
        neg = 1;
      end else if (cz < -longint'(odo_pkg::HalfPiQ)) begin
        cz += odo_pkg::PiQ;
        neg = 1;
      end
      for (int i = 0; i < odo_pkg::CordicIters; i++) begin
        if (cz >= 0) begin
          t = cx - shr_floor(cy, i);
          cy = cy + shr_floor(cx, i);
          cz -= atan_table(i);
        end else begin
          t = cx + shr_floor(cy, i);
          cy = cy - shr_floor(cx, i);
          cz += atan_table(i);
        end
        cx = t;
      end
      if (neg) begin
        cx = -cx;
        cy = -cy;
      end
      travel = (dl + dr) * longint'(dpc);
      px = px + 32'(scale47(travel, cx));
      py = py + 32'(scale47(travel, cy));
      // Heading change, saturated at two pi.
      diff = dr - dl;
      num = longint'(diff < 0 ? -diff : diff) * dpc;
      qh = num / tw;
      if (qh > (longint'(odo_pkg::TwoPiQ) >> 12)) q = odo_pkg::TwoPiQ;
      else begin
        q = (qh << 12) + (((num % tw) << 12) / tw);
        if (q > longint'(odo_pkg::TwoPiQ)) q = odo_pkg::TwoPiQ;
      end
      dh = diff < 0 ? -longint'(q) : longint'(q);
      phead = 32'(fold_heading(h + dh));
      // Velocities.
      sd = longint'(rq.right_rate) + longint'(rq.left_rate);
      mag = (longint'(sd < 0 ? -sd : sd) * dpc) >> 17;
      lin = sd < 0 ? -longint'(mag) : longint'(mag);
      sd = longint'(rq.right_rate) - longint'(rq.left_rate);
      mag = (longint'(sd < 0 ? -sd : sd) * dpc) / tw;
      if (sd < 0) ang = mag > 64'h8000_0000 ? -64'sh8000_0000 : -longint'(mag);
      else ang = mag > 64'h7fff_ffff ? 64'sh7fff_ffff : longint'(mag);
    end
    res.pos_x = px;
    res.pos_y = py;
    res.pos_heading = phead[30:0];
    res.lin_velocity = lin[31:0];
    res.ang_velocity = ang[31:0];
    return res;
  endfunction

  // Driver: bursts with random gaps; valid holds until the request is taken.
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= odo_pkg::OpSample;
      left_count_i <= '0;
      right_count_i <= '0;
      left_rate_i <= '0;
      right_rate_i <= '0;
      new_x_i <= '0;
      new_y_i <= '0;
      new_heading_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      logic fire, send;
      odo_req_t rq;
      fire = in_valid_i && in_ready_o;
      if (fire) begin
        expected_poses.push_back(odo_predict(pending_reqs.pop_front()));
      end
      if (in_valid_i && !fire) begin
        // Hold the current request.
      end else begin
        send = 0;
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (pending_reqs.size() > 0) begin
          send = 1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
        in_valid_i <= send;
        if (send) begin
          rq = pending_reqs[0];
          op_i <= rq.op;
          left_count_i <= rq.left_count;
          right_count_i <= rq.right_count;
          left_rate_i <= rq.left_rate;
          right_rate_i <= rq.right_rate;
          new_x_i <= rq.new_x;
          new_y_i <= rq.new_y;
          new_heading_i <= rq.new_heading;
        end
      end
    end
  end

  // Receiver stall pattern plus one long hold-off.
  int stall_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (hold_off) out_ready_i <= 1'b0;
      else if (stall_phase[11:10] == 2'd0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      pose_t exp_pose;
      if (expected_poses.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        exp_pose = expected_poses.pop_front();
        if (pos_x_o !== exp_pose.pos_x) begin
          $error("pos_x expected %0d got %0d", exp_pose.pos_x, pos_x_o);
          errors++;
        end
        if (pos_y_o !== exp_pose.pos_y) begin
          $error("pos_y expected %0d got %0d", exp_pose.pos_y, pos_y_o);
          errors++;
        end
        if (pos_heading_o !== exp_pose.pos_heading) begin
          $error("pos_heading expected %0d got %0d", exp_pose.pos_heading, pos_heading_o);
          errors++;
        end
        if (lin_velocity_o !== exp_pose.lin_velocity) begin
          $error("lin_velocity expected %0d got %0d", exp_pose.lin_velocity,
                 lin_velocity_o);
          errors++;
        end
        if (ang_velocity_o !== exp_pose.ang_velocity) begin
          $error("ang_velocity expected %0d got %0d", exp_pose.ang_velocity,
                 ang_velocity_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || hold_off || stim_done
        || (pending_reqs.size() == 0 && expected_poses.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  function automatic odo_req_t rand_req(int mode);
    odo_req_t rq;
    rq.op = ($urandom_range(0, 9) == 0) ? odo_pkg::OpLoad : odo_pkg::OpSample;
    rq.left_count = $urandom;
    rq.right_count = $urandom;
    rq.left_rate = 16'($urandom);
    rq.right_rate = 16'($urandom);
    rq.new_x = $urandom;
    rq.new_y = $urandom;
    rq.new_heading = 31'($urandom_range(0, 1686629713) - 843314856);
    if (rq.op == odo_pkg::OpLoad && $urandom_range(0, 4) == 0) rq.new_heading = 31'($urandom);
    // Mostly small moves so the pose walks around smoothly.
    if (mode != 0 && $urandom_range(0, 7) != 0) begin
      rq.left_count = cur_left + $signed($urandom_range(0, 2000)) - 1000;
      rq.right_count = cur_right + $signed($urandom_range(0, 2000)) - 1000;
      rq.left_rate = 16'($signed($urandom_range(0, 4000)) - 2000);
      rq.right_rate = 16'($signed($urandom_range(0, 4000)) - 2000);
    end
    if (rq.op == odo_pkg::OpSample) begin
      cur_left = rq.left_count;
      cur_right = rq.right_count;
    end
    return rq;
  endfunction

  task automatic queue_req(logic op, int l, int r, int lr, int rr, int x, int y, int hd);
    odo_req_t rq;
    rq.op = op;
    rq.left_count = l;
    rq.right_count = r;
    rq.left_rate = 16'(lr);
    rq.right_rate = 16'(rr);
    rq.new_x = x;
    rq.new_y = y;
    rq.new_heading = 31'(hd);
    if (op == odo_pkg::OpSample) begin
      cur_left = l;
      cur_right = r;
    end
    pending_reqs.push_back(rq);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_poses.size() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [27:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == odo_pkg::RegDistPerCount) dpc = val;
    else track = val[19:0];
  endtask

  logic [27:0] dpc_set[5];
  logic [19:0] tw_set[5];

  initial begin
    hold_off = 0;
    stim_done = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = odo_pkg::RegDistPerCount;
    cfg_wdata_i = '0;
    dpc = odo_pkg::DpcReset;
    track = odo_pkg::TwReset;
    prev_left = '0;
    prev_right = '0;
    px = '0;
    py = '0;
    phead = '0;
    cur_left = '0;
    cur_right = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first sample against zero, extremes, loads, wrap and saturation.
    queue_req(odo_pkg::OpSample, 100, 140, 300, 420, 0, 0, 0);
    queue_req(odo_pkg::OpSample, 32'sh7fffffff, 32'sh80000000, 16'sh7fff, 16'sh8000,
              0, 0, 0);
    queue_req(odo_pkg::OpSample, 32'sh80000000, 32'sh7fffffff, 16'sh8000, 16'sh7fff,
              0, 0, 0);
    queue_req(odo_pkg::OpSample, -5, -5, -1, -1, 0, 0, 0);
    queue_req(odo_pkg::OpLoad, 1, 2, 3, 4, 32'sh7fffffff, 32'sh80000000, 31'sd843314857);
    queue_req(odo_pkg::OpSample, 20, -5, 16'sh8000, 16'sh8000, 0, 0, 0);
    queue_req(odo_pkg::OpLoad, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, -31'sd843314856);
    queue_req(odo_pkg::OpSample, 30, 10, 16'sh7fff, 16'sh7fff, 0, 0, 0);
    queue_req(odo_pkg::OpLoad, 0, 0, 0, 0, 0, 0, 31'sh3fffffff);
    queue_req(odo_pkg::OpLoad, 0, 0, 0, 0, 0, 0, 31'sh40000000);
    queue_req(odo_pkg::OpLoad, 0, 0, 0, 0, -1, -1, 31'sd421657429);
    queue_req(odo_pkg::OpSample, 1030, 1040, 0, 0, 0, 0, 0);
    queue_req(odo_pkg::OpLoad, 0, 0, 0, 0, 0, 0, -31'sd421657429);
    queue_req(odo_pkg::OpSample, 2030, 2010, 5, -5, 0, 0, 0);
    queue_req(odo_pkg::OpSample, 2030, 2010, 0, 0, 0, 0, 0);
    drain();

    // Zero track width and large distance per count: heading and ang saturate.
    write_reg(odo_pkg::RegTrackWidth, 28'd0);
    write_reg(odo_pkg::RegDistPerCount, 28'hfffffff);
    queue_req(odo_pkg::OpSample, cur_left - 100000, cur_right + 100000, 16'sh8000,
              16'sh7fff, 0, 0, 0);
    queue_req(odo_pkg::OpSample, cur_left + 3, cur_right - 3, 16'sh7fff, 16'sh8000,
              0, 0, 0);
    queue_req(odo_pkg::OpSample, cur_left, cur_right + 1, 16'sh7fff, 16'sh7fff, 0, 0, 0);
    drain();

    dpc_set = '{28'd1, 28'hfffffff, 28'd29033979, 28'd5000000, 28'd123456};
    tw_set = '{20'hfffff, 20'd1, 20'd26411, 20'd40000, 20'd0};
    for (int phase = 0; phase < 5; phase++) begin
      write_reg(odo_pkg::RegDistPerCount, dpc_set[phase]);
      write_reg(odo_pkg::RegTrackWidth, {8'd0, tw_set[phase]});
      for (int n = 0; n < ItemCount / 5; n++) pending_reqs.push_back(rand_req(1));
      if (phase == 2) begin
        // Long receiver hold-off while requests keep coming.
        hold_off = 1;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end
      drain();
    end

    stim_done = 1;
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

// File: sim.f
src/odo_pkg.sv
src/odo_cordic.sv
src/odo_div.sv
src/differential_drive_odometry_top.sv
src/odo_checker.sv
test/tb_top.sv
